FILE: design/wftp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the weighted fair task picker.
// No dependencies; used by every module of the block.
package wftp_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int TAG_W          = 8;
    localparam int WORK_W         = 24;
    localparam int META_W         = 3 * TAG_W;
    localparam int QUOT_W         = WORK_W + 8;
    localparam int MIN_W          = 31;
    localparam int DIV_STEP       = 8;
    localparam int DIV_CYCLES     = QUOT_W / DIV_STEP;

    localparam logic [TAG_W-1:0]  SLICES_RESET  = 8'd20;
    localparam logic [WORK_W-1:0] WORK_MAX      = 24'hFFFFFF;
    localparam logic [QUOT_W-1:0] SCORE_ZERO_W  = 32'd100000000;
    localparam logic [MIN_W-1:0]  SCORE_START   = 31'd2000000000;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_COMPLETE = 2'd2,
        OP_PURGE    = 2'd3
    } t_op;

    // Strobes from the sequencer to the task table.
    typedef struct packed {
        logic rd;
        logic meta_we;
        logic work_we;
    } t_tbl_ctl;

endpackage

FILE: design/wftp_table.sv
`timescale 1ns / 1ps
// Task table: descriptor memory (tag, weight, owner) and work-count memory.
// One write and one registered read per cycle each; depends on wftp_pkg.
module wftp_table #(
    parameter int TASK_SLOTS = wftp_pkg::TASK_SLOTS_DEF,
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  logic                        i_clk,
    input  wftp_pkg::t_tbl_ctl          i_ctl,
    input  logic [IW-1:0]               i_raddr,
    input  logic [IW-1:0]               i_waddr,
    input  logic [wftp_pkg::META_W-1:0] i_meta_wdata,
    input  logic [wftp_pkg::WORK_W-1:0] i_work_wdata,
    output logic [wftp_pkg::META_W-1:0] o_meta_rdata,
    output logic [wftp_pkg::WORK_W-1:0] o_work_rdata
);

    logic [wftp_pkg::META_W-1:0] r_meta_mem [TASK_SLOTS];
    logic [wftp_pkg::WORK_W-1:0] r_work_mem [TASK_SLOTS];
    logic [wftp_pkg::META_W-1:0] r_meta_q;
    logic [wftp_pkg::WORK_W-1:0] r_work_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.meta_we) begin
            r_meta_mem[i_waddr] <= i_meta_wdata;
        end
        if (i_ctl.work_we) begin
            r_work_mem[i_waddr] <= i_work_wdata;
        end
        if (i_ctl.rd) begin
            r_meta_q <= r_meta_mem[i_raddr];
            r_work_q <= r_work_mem[i_raddr];
        end
    end

    assign o_meta_rdata = r_meta_q;
    assign o_work_rdata = r_work_q;

endmodule

FILE: design/wftp_div.sv
`timescale 1ns / 1ps
// Shared score divider: (work * 256) / weight, eight quotient bits per cycle.
// Restoring division over an 8-bit divisor; depends on wftp_pkg.
module wftp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [wftp_pkg::WORK_W-1:0] i_work,
    input  logic [7:0]                  i_weight,
    output logic                        o_done,
    output logic [wftp_pkg::QUOT_W-1:0] o_quot
);

    localparam int CNT_W = (wftp_pkg::DIV_CYCLES > 1) ? $clog2(wftp_pkg::DIV_CYCLES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wftp_pkg::DIV_CYCLES - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [wftp_pkg::QUOT_W-1:0] r_q;
    logic [7:0]                  r_rem;
    logic [7:0]                  r_div;
    logic [wftp_pkg::QUOT_W-1:0] n_q;
    logic [7:0]                  n_rem;

    // The dividend bits shift out of the top of r_q while quotient bits
    // shift in at the bottom.
    always_comb begin
        logic [8:0] t;
        n_rem = r_rem;
        n_q   = r_q;
        for (int k = 0; k < wftp_pkg::DIV_STEP; k++) begin
            t = {n_rem, n_q[wftp_pkg::QUOT_W-1]};
            if (t >= {1'b0, r_div}) begin
                n_rem = 8'(t - {1'b0, r_div});
                n_q   = {n_q[wftp_pkg::QUOT_W-2:0], 1'b1};
            end else begin
                n_rem = t[7:0];
                n_q   = {n_q[wftp_pkg::QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {i_work, 8'b0};
            r_rem <= '0;
            r_div <= i_weight;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

FILE: design/weighted_fair_task_picker_core.sv
`timescale 1ns / 1ps
// Weighted fair task picker: an ordered task table with add, tick, complete
// and purge-by-owner commands. Uses wftp_pkg, wftp_table and wftp_div.
//
// Usage: one command word enters on the s_axis channel (tuser = opcode,
// tdata = tag, priority, owner) and exactly one result word leaves on the
// m_axis channel. The slice size is written on the cfg channel while idle.
// The block handles one command at a time and is not ready meanwhile.
// Work per command with H tasks held, from accept to result register:
//   add: one write of the new entry, then a clear of every work count;
//   add to a full table and tick on an empty table go straight to the result,
//   tick: per task a table read, the divider start and wait (skipped for a
//   zero weight) and the compare, then one write-back of the chosen count,
//   complete and purge: per task a table read and a check with a copy-down.
// All table passes go through a single read port and a single write port,
// one entry per step.
// Reset empties the table and sets the slice size to 20. A result waits in
// the output register while the receiver stalls; the next command can be
// taken meanwhile, and its result is held back until the register frees.
module weighted_fair_task_picker_core #(
    parameter int TASK_SLOTS = wftp_pkg::TASK_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // task_tag, task_priority, owner_id
    input  logic [1:0]  i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // selected_tag, removed_count, tasks_held, zeros
    output logic [1:0]  o_m_axis_tuser,   // selected_valid, add_accepted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(TASK_SLOTS);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_ADD      = 11'b00000000010,
        S_ADD_CLR  = 11'b00000000100,
        S_TICK_RD  = 11'b00000001000,
        S_TICK_ST  = 11'b00000010000,
        S_TICK_DIV = 11'b00000100000,
        S_TICK_CMP = 11'b00001000000,
        S_TICK_WB  = 11'b00010000000,
        S_SCAN_RD  = 11'b00100000000,
        S_SCAN_CHK = 11'b01000000000,
        S_RESP     = 11'b10000000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_held, n_held;
    logic [7:0]          r_slices, n_slices;
    logic [CW-1:0]       r_rd, n_rd;
    logic [CW-1:0]       r_wr, n_wr;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;

    wftp_pkg::t_op       r_op, n_op;
    logic [7:0]          r_tag, n_tag;
    logic [7:0]          r_prio, n_prio;
    logic [7:0]          r_owner, n_owner;
    logic [IW-1:0]       r_best, n_best;
    logic [wftp_pkg::WORK_W-1:0] r_best_work, n_best_work;
    logic [7:0]          r_best_tag, n_best_tag;
    logic [wftp_pkg::MIN_W-1:0]  r_min, n_min;
    logic [wftp_pkg::WORK_W-1:0] r_cur_work, n_cur_work;
    logic [7:0]          r_cur_tag, n_cur_tag;
    logic [wftp_pkg::QUOT_W-1:0] r_score, n_score;
    logic                r_res_sel, n_res_sel;
    logic [7:0]          r_res_tag, n_res_tag;
    logic                r_res_add, n_res_add;
    logic [CW-1:0]       r_res_rm, n_res_rm;
    logic                r_o_sel, n_o_sel;
    logic [7:0]          r_o_tag, n_o_tag;
    logic                r_o_add, n_o_add;
    logic [4:0]          r_o_rm, n_o_rm;
    logic [4:0]          r_o_held, n_o_held;

    wftp_pkg::t_tbl_ctl          w_ctl;
    logic [IW-1:0]               w_raddr;
    logic [IW-1:0]               w_waddr;
    logic [wftp_pkg::META_W-1:0] w_meta_wdata;
    logic [wftp_pkg::WORK_W-1:0] w_work_wdata;
    logic [wftp_pkg::META_W-1:0] w_meta_rd;
    logic [wftp_pkg::WORK_W-1:0] w_work_rd;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [wftp_pkg::QUOT_W-1:0] w_quot;
    logic [wftp_pkg::WORK_W-1:0] w_cur_work_src;

    logic [CW-1:0]         w_rd_inc;
    logic [CW-1:0]         w_wr_inc;
    logic                  w_lt;
    logic                  w_drop;
    logic [wftp_pkg::WORK_W:0] w_sum;
    logic [CW+4:0]         w_rm_ext;
    logic [CW+4:0]         w_held_ext;

    wftp_table #(.TASK_SLOTS(TASK_SLOTS)) u_table (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_raddr      (w_raddr),
        .i_waddr      (w_waddr),
        .i_meta_wdata (w_meta_wdata),
        .i_work_wdata (w_work_wdata),
        .o_meta_rdata (w_meta_rd),
        .o_work_rdata (w_work_rd)
    );

    wftp_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_work   (w_cur_work_src),
        .i_weight (w_meta_rd[15:8]),
        .o_done   (w_div_done),
        .o_quot   (w_quot)
    );

    assign w_cur_work_src = w_work_rd;

    assign w_rd_inc   = r_rd + 1'b1;
    assign w_wr_inc   = r_wr + 1'b1;
    assign w_lt       = r_score < {1'b0, r_min};
    assign w_sum      = {1'b0, r_best_work} + {{(wftp_pkg::WORK_W - 7){1'b0}}, r_slices};
    assign w_rm_ext   = {5'b0, r_res_rm};
    assign w_held_ext = {5'b0, r_held};
    // Complete drops only the first tag match; purge drops every owner match.
    assign w_drop     = (r_op == wftp_pkg::OP_COMPLETE) ?
                        (!r_found && (w_meta_rd[7:0] == r_tag)) :
                        (w_meta_rd[23:16] == r_owner);

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_slices    = i_cfg_valid ? i_cfg_data : r_slices;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_op        = r_op;
        n_tag       = r_tag;
        n_prio      = r_prio;
        n_owner     = r_owner;
        n_best      = r_best;
        n_best_work = r_best_work;
        n_best_tag  = r_best_tag;
        n_min       = r_min;
        n_cur_work  = r_cur_work;
        n_cur_tag   = r_cur_tag;
        n_score     = r_score;
        n_res_sel   = r_res_sel;
        n_res_tag   = r_res_tag;
        n_res_add   = r_res_add;
        n_res_rm    = r_res_rm;
        n_o_sel     = r_o_sel;
        n_o_tag     = r_o_tag;
        n_o_add     = r_o_add;
        n_o_rm      = r_o_rm;
        n_o_held    = r_o_held;
        w_ctl        = '0;
        w_raddr      = r_rd[IW-1:0];
        w_waddr      = r_wr[IW-1:0];
        w_meta_wdata = w_meta_rd;
        w_work_wdata = w_work_rd;
        w_div_start  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_op      = wftp_pkg::t_op'(i_s_axis_tuser);
                    n_tag     = i_s_axis_tdata[7:0];
                    n_prio    = i_s_axis_tdata[15:8];
                    n_owner   = i_s_axis_tdata[23:16];
                    n_rd      = '0;
                    n_wr      = '0;
                    n_found   = 1'b0;
                    n_min     = wftp_pkg::SCORE_START;
                    n_res_sel = 1'b0;
                    n_res_tag = '0;
                    n_res_add = 1'b0;
                    n_res_rm  = '0;
                    unique case (wftp_pkg::t_op'(i_s_axis_tuser)) inside
                        wftp_pkg::OP_ADD: begin
                            n_state = (r_held == FULL) ? S_RESP : S_ADD;
                        end
                        wftp_pkg::OP_TICK: begin
                            n_state = (r_held == '0) ? S_RESP : S_TICK_RD;
                        end
                        wftp_pkg::OP_COMPLETE, wftp_pkg::OP_PURGE: begin
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_ADD: begin
                w_ctl.meta_we = 1'b1;
                w_waddr       = r_held[IW-1:0];
                w_meta_wdata  = {r_owner, r_prio, r_tag};
                n_held        = r_held + 1'b1;
                n_wr          = '0;
                n_state       = S_ADD_CLR;
            end
            S_ADD_CLR: begin
                // Every count, the new task's included, restarts at zero.
                w_ctl.work_we = 1'b1;
                w_work_wdata  = '0;
                n_wr          = w_wr_inc;
                if (w_wr_inc == r_held) begin
                    n_res_add = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_TICK_RD: begin
                w_ctl.rd = 1'b1;
                n_state  = S_TICK_ST;
            end
            S_TICK_ST: begin
                n_cur_work = w_work_rd;
                n_cur_tag  = w_meta_rd[7:0];
                if (w_meta_rd[15:8] == 8'd0) begin
                    n_score = wftp_pkg::SCORE_ZERO_W;
                    n_state = S_TICK_CMP;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_TICK_DIV;
                end
            end
            S_TICK_DIV: begin
                if (w_div_done) begin
                    n_score = w_quot;
                    n_state = S_TICK_CMP;
                end
            end
            S_TICK_CMP: begin
                // The first task stands as the choice until a later score beats both
                // the start value and every earlier score; ties keep the earlier task.
                if (w_lt) begin
                    n_min = r_score[wftp_pkg::MIN_W-1:0];
                end
                if (w_lt || (r_rd == '0)) begin
                    n_best      = r_rd[IW-1:0];
                    n_best_work = r_cur_work;
                    n_best_tag  = r_cur_tag;
                end
                n_rd    = w_rd_inc;
                n_state = (w_rd_inc == r_held) ? S_TICK_WB : S_TICK_RD;
            end
            S_TICK_WB: begin
                w_ctl.work_we = 1'b1;
                w_waddr       = r_best;
                w_work_wdata  = w_sum[wftp_pkg::WORK_W] ? wftp_pkg::WORK_MAX :
                                w_sum[wftp_pkg::WORK_W-1:0];
                n_res_sel     = 1'b1;
                n_res_tag     = r_best_tag;
                n_state       = S_RESP;
            end
            S_SCAN_RD: begin
                if (r_rd == r_held) begin
                    n_held   = r_wr;
                    n_res_rm = r_held - r_wr;
                    n_state  = S_RESP;
                end else begin
                    w_ctl.rd = 1'b1;
                    n_state  = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                // Kept tasks are copied down to the write pointer in order.
                if (w_drop) begin
                    n_found = 1'b1;
                end else begin
                    w_ctl.meta_we = 1'b1;
                    w_ctl.work_we = 1'b1;
                    n_wr          = w_wr_inc;
                end
                n_rd    = w_rd_inc;
                n_state = S_SCAN_RD;
            end
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_o_sel     = r_res_sel;
                    n_o_tag     = r_res_tag;
                    n_o_add     = r_res_add;
                    n_o_rm      = w_rm_ext[4:0];
                    n_o_held    = w_held_ext[4:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_slices    <= wftp_pkg::SLICES_RESET;
            r_rd        <= '0;
            r_wr        <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_slices    <= n_slices;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_tag       <= n_tag;
        r_prio      <= n_prio;
        r_owner     <= n_owner;
        r_best      <= n_best;
        r_best_work <= n_best_work;
        r_best_tag  <= n_best_tag;
        r_min       <= n_min;
        r_cur_work  <= n_cur_work;
        r_cur_tag   <= n_cur_tag;
        r_score     <= n_score;
        r_res_sel   <= n_res_sel;
        r_res_tag   <= n_res_tag;
        r_res_add   <= n_res_add;
        r_res_rm    <= n_res_rm;
        r_o_sel     <= n_o_sel;
        r_o_tag     <= n_o_tag;
        r_o_add     <= n_o_add;
        r_o_rm      <= n_o_rm;
        r_o_held    <= n_o_held;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_o_held, r_o_rm, r_o_tag};
    assign o_m_axis_tuser  = {r_o_add, r_o_sel};
    assign o_cfg_ready     = 1'b1;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= FULL)
        else $error("task count exceeds table depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state != S_IDLE))
        else $error("accepted command did not start work");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_wr <= r_rd))
        else $error("compaction write pointer passed read pointer");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_TICK_DIV))
        else $error("divider finished outside of a tick");

endmodule
